@@ rtl/xalu_pkg.sv @@
`default_nettype none

package xalu_pkg;

  // Stream word widths; the data widths are padded to whole bytes
  localparam int unsigned InDataW  = 72;
  localparam int unsigned InUserW  = 6;
  localparam int unsigned OutDataW = 40;

  // Operation codes
  typedef enum logic [3:0] {
    ACT_ADD = 4'd0,
    ACT_ADC = 4'd1,
    ACT_SUB = 4'd2,
    ACT_SBB = 4'd3,
    ACT_CMP = 4'd4,
    ACT_AND = 4'd5,
    ACT_OR  = 4'd6,
    ACT_XOR = 4'd7,
    ACT_SHL = 4'd8
  } action_e;

  // Operand size codes; the unused code behaves as doubleword
  typedef enum logic [1:0] {
    WIDTH_BYTE  = 2'd0,
    WIDTH_WORD  = 2'd1,
    WIDTH_DWORD = 2'd2
  } width_e;

  // One operation request
  typedef struct packed {
    logic [3:0]  action;
    logic [1:0]  width_sel;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic        carry_in;
  } req_t;

  // One operation result with its flags
  typedef struct packed {
    logic [31:0] result;
    logic        write_back;
    logic        flag_carry;
    logic        flag_parity;
    logic        flag_aux;
    logic        flag_zero;
    logic        flag_sign;
    logic        flag_overflow;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/x86_alu_with_flags_unit.sv @@
// x86 integer ALU with status flags.
// Slave channel: one word per operation. tdata carries operand_a [31:0],
// operand_b [63:32], carry_in [64], zero fill above. tuser carries the
// operation code [3:0] and the operand size [5:4].
// Master channel: one word per operation. tdata carries result [31:0],
// write_back [32], CF [33], PF [34], AF [35], ZF [36], SF [37], OF [38],
// zero at [39].
// Path: a taken input word passes the input register, then the ALU logic
// into the result register, and leaves the master side from the result
// register.
// Throughput: one operation per cycle while the receiver takes results;
// the two register stages let a new word in while a result waits.
// Reset clears both stage valid bits; no word is held or issued after it.
// When the receiver stalls, the result register holds its word, the input
// register fills, and tready on the slave side drops once both are full.
`default_nettype none

module x86_alu_with_flags_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // operand_a [31:0], operand_b [63:32], carry_in [64], zeros [71:65]
  input  wire logic [xalu_pkg::InDataW-1:0]  s_axis_tdata_i,
  // action [3:0], width_sel [5:4]
  input  wire logic [xalu_pkg::InUserW-1:0]  s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // result [31:0], write_back, flag_carry, flag_parity, flag_aux,
  // flag_zero, flag_sign, flag_overflow [38:32], zero [39]
  output logic [xalu_pkg::OutDataW-1:0]      m_axis_tdata_o
);
  import xalu_pkg::*;

  logic in_valid_q;
  req_t in_q;
  req_t in_d;
  logic out_valid_q;
  res_t out_q;
  res_t out_d;
  logic out_ready;
  logic in_ready;

  // Unpack the incoming word
  always_comb begin
    in_d.action    = s_axis_tuser_i[3:0];
    in_d.width_sel = s_axis_tuser_i[5:4];
    in_d.operand_a = s_axis_tdata_i[31:0];
    in_d.operand_b = s_axis_tdata_i[63:32];
    in_d.carry_in  = s_axis_tdata_i[64];
  end

  // Stage handshakes
  assign out_ready = ~out_valid_q | m_axis_tready_i;
  assign in_ready  = ~in_valid_q | out_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && in_ready) begin
      in_q <= in_d;
    end
  end

  // ALU logic
  xalu_core u_core (
    .req_i (in_q),
    .res_o (out_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q && out_ready) begin
      out_q <= out_d;
    end
  end

  // Drive the outgoing word
  assign s_axis_tready_o = in_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q.flag_overflow, out_q.flag_sign, out_q.flag_zero,
                            out_q.flag_aux, out_q.flag_parity, out_q.flag_carry,
                            out_q.write_back, out_q.result};

  // Slave side stalls only with both stages full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && out_valid_q))
    else $error("slave stalled with a free stage");

  // A moving input stage word lands in the result register
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_ready) |=> out_valid_q)
    else $error("word lost between stages");

  // Zero flag agrees with the registered result
  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.flag_zero) |-> (out_q.result == '0))
    else $error("zero flag set on nonzero result");

  // Parity flag matches the low byte, except for the all-clear unknown case
  a_parity_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.flag_parity) |-> !(^out_q.result[7:0]))
    else $error("parity flag wrong");

endmodule

`default_nettype wire

@@ rtl/xalu_core.sv @@
`default_nettype none

module xalu_core (
  input  xalu_pkg::req_t req_i,
  output xalu_pkg::res_t res_o
);
  import xalu_pkg::*;

  logic [31:0] mask;
  logic [31:0] top;
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] bx;
  logic        is_sub;
  logic        cin;
  logic [32:0] sum;
  logic [31:0] sum_res;
  logic        sum_cout;
  logic [31:0] res;
  logic        valid;
  logic        wb;
  logic        cf;
  logic        af;
  logic        of;

  // Size mask and sign-bit position
  always_comb begin
    case (req_i.width_sel)
      WIDTH_BYTE: begin
        mask = 32'h0000_00ff;
        top  = 32'h0000_0080;
      end
      WIDTH_WORD: begin
        mask = 32'h0000_ffff;
        top  = 32'h0000_8000;
      end
      default: begin
        mask = 32'hffff_ffff;
        top  = 32'h8000_0000;
      end
    endcase
  end

  assign a = req_i.operand_a & mask;
  assign b = req_i.operand_b & mask;

  // Adder: subtraction adds the inverted operand
  assign is_sub = (req_i.action == ACT_SUB) || (req_i.action == ACT_SBB) ||
                  (req_i.action == ACT_CMP);
  assign bx     = is_sub ? (~b & mask) : b;

  always_comb begin
    case (req_i.action)
      ACT_ADD: cin = 1'b0;
      ACT_ADC: cin = req_i.carry_in;
      ACT_SBB: cin = ~req_i.carry_in;
      default: cin = 1'b1;
    endcase
  end

  assign sum     = {1'b0, a} + {1'b0, bx} + {32'd0, cin};
  assign sum_res = sum[31:0] & mask;

  // Carry out of the selected top bit
  always_comb begin
    case (req_i.width_sel)
      WIDTH_BYTE: sum_cout = sum[8];
      WIDTH_WORD: sum_cout = sum[16];
      default:    sum_cout = sum[32];
    endcase
  end

  // Select result and operation-specific flags
  always_comb begin
    res   = '0;
    valid = 1'b1;
    wb    = 1'b1;
    cf    = 1'b0;
    af    = 1'b0;
    of    = 1'b0;
    case (req_i.action)
      ACT_ADD, ACT_ADC, ACT_SUB, ACT_SBB, ACT_CMP: begin
        res = sum_res;
        cf  = sum_cout ^ is_sub;
        af  = a[4] ^ b[4] ^ sum_res[4];
        of  = |((a ^ sum_res) & (bx ^ sum_res) & top);
        wb  = (req_i.action != ACT_CMP);
      end
      ACT_AND: res = a & b;
      ACT_OR:  res = a | b;
      ACT_XOR: res = a ^ b;
      ACT_SHL: begin
        res = {a[30:0], 1'b0} & mask;
        cf  = |(a & top);
        of  = cf ^ (|(a & (top >> 1)));
      end
      default: valid = 1'b0;
    endcase
  end

  // Common flags; an unknown operation drives everything low
  always_comb begin
    res_o.result        = valid ? res : '0;
    res_o.write_back    = valid & wb;
    res_o.flag_carry    = valid & cf;
    res_o.flag_parity   = valid & ~(^res[7:0]);
    res_o.flag_aux      = valid & af;
    res_o.flag_zero     = valid & (res == '0);
    res_o.flag_sign     = valid & (|(res & top));
    res_o.flag_overflow = valid & of;
  end

endmodule

`default_nettype wire

@@ sim/tb_x86_alu_with_flags_unit.sv @@
`timescale 1ns / 1ps

module tb_x86_alu_with_flags_unit;
  import xalu_pkg::*;

  localparam int unsigned RAND_PER_PHASE = 643;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned TAIL_CYCLES    = 10;
  localparam int unsigned REPORT_MAX     = 10;
  localparam int unsigned DIR_ROWS       = 24;

  // Codes outside the enums: spare size code and unknown operations
  localparam logic [1:0] WIDTH_SPARE    = 2'd3;
  localparam logic [3:0] ACT_UNKNOWN_LO = 4'd9;
  localparam logic [3:0] ACT_UNKNOWN_HI = 4'd15;

  // One operation word plus an optional hand-worked result
  typedef struct packed {
    req_t req;
    logic fixed;
    res_t want;
  } alu_op_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [InUserW-1:0]  s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  alu_op_t     directed_ops [DIR_ROWS];
  alu_op_t     op_queue [$];
  res_t        results_due [$];
  alu_op_t     cur_op;
  res_t        seen_res;
  res_t        due_res;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned ops_sent        = 0;
  int unsigned results_checked = 0;
  int unsigned fail_count      = 0;
  int unsigned stall_cycles    = 0;

  x86_alu_with_flags_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Predict result and flags of one operation
  function automatic res_t alu_flags_predict(req_t r);
    logic [31:0] mask, top, a, b, bx, res, half;
    logic [32:0] sum;
    logic        c, sub, known;
    int unsigned nbits;
    res_t        o;
    o = '0;
    res = '0;
    known = 1'b1;
    case (r.width_sel)
      WIDTH_BYTE: nbits = 8;
      WIDTH_WORD: nbits = 16;
      default:    nbits = 32;
    endcase
    mask = (nbits == 32) ? 32'hffff_ffff : ((32'd1 << nbits) - 32'd1);
    top  = 32'd1 << (nbits - 1);
    a    = r.operand_a & mask;
    b    = r.operand_b & mask;
    o.write_back = 1'b1;
    case (r.action)
      ACT_ADD, ACT_ADC, ACT_SUB, ACT_SBB, ACT_CMP: begin
        sub = (r.action == ACT_SUB) || (r.action == ACT_SBB) || (r.action == ACT_CMP);
        bx  = sub ? (~b & mask) : b;
        if (r.action == ACT_ADD) c = 1'b0;
        else if (r.action == ACT_ADC) c = r.carry_in;
        else if (r.action == ACT_SBB) c = ~r.carry_in;
        else c = 1'b1;
        sum  = {1'b0, a} + {1'b0, bx} + {32'd0, c};
        res  = sum[31:0] & mask;
        half = a ^ b ^ res;
        o.flag_carry    = sum[nbits] ^ sub;
        o.flag_aux      = half[4];
        o.flag_overflow = |((a ^ res) & (bx ^ res) & top);
        o.write_back    = (r.action != ACT_CMP);
      end
      ACT_AND: res = a & b;
      ACT_OR:  res = a | b;
      ACT_XOR: res = a ^ b;
      ACT_SHL: begin
        res = (a << 1) & mask;
        o.flag_carry    = |(a & top);
        o.flag_overflow = o.flag_carry ^ (|(a & (top >> 1)));
      end
      default: known = 1'b0;
    endcase
    if (!known) return '0;
    o.result      = res;
    o.flag_parity = ~^res[7:0];
    o.flag_zero   = (res == 32'd0);
    o.flag_sign   = |(res & top);
    return o;
  endfunction

  // Favor width boundaries, single bits and all-ones
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(5))
      0:       return 32'h0;
      1:       return 32'hffff_ffff;
      2:       return 32'd1 << $urandom_range(31);
      3:       return ~(32'd1 << $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t random_req();
    req_t r;
    if ($urandom_range(19) == 0) r.action = 4'($urandom_range(ACT_UNKNOWN_HI, ACT_UNKNOWN_LO));
    else r.action = 4'($urandom_range(ACT_SHL));
    if ($urandom_range(9) == 0) r.width_sel = WIDTH_SPARE;
    else r.width_sel = 2'($urandom_range(WIDTH_DWORD));
    r.operand_a = pick_operand();
    r.operand_b = pick_operand();
    r.carry_in  = 1'($urandom_range(1));
    return r;
  endfunction

  function automatic string fmt_res(res_t r);
    return $sformatf("result %h wb %b CF %b PF %b AF %b ZF %b SF %b OF %b",
                     r.result, r.write_back, r.flag_carry, r.flag_parity, r.flag_aux,
                     r.flag_zero, r.flag_sign, r.flag_overflow);
  endfunction

  // Drive operation words; record the expected result when a word is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        results_due.push_back(cur_op.fixed ? cur_op.want : alu_flags_predict(cur_op.req));
        ops_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_op = op_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'd0, cur_op.req.carry_in, cur_op.req.operand_b,
                            cur_op.req.operand_a};
          s_axis_tuser  <= {cur_op.req.width_sel, cur_op.req.action};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Stall the result side at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_res.result        = m_axis_tdata[31:0];
      seen_res.write_back    = m_axis_tdata[32];
      seen_res.flag_carry    = m_axis_tdata[33];
      seen_res.flag_parity   = m_axis_tdata[34];
      seen_res.flag_aux      = m_axis_tdata[35];
      seen_res.flag_zero     = m_axis_tdata[36];
      seen_res.flag_sign     = m_axis_tdata[37];
      seen_res.flag_overflow = m_axis_tdata[38];
      if (results_due.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("%0t: result word with nothing expected: %s", $realtime, fmt_res(seen_res));
      end else begin
        due_res = results_due.pop_front();
        results_checked++;
        if (seen_res.result !== due_res.result ||
            seen_res.write_back !== due_res.write_back ||
            seen_res.flag_carry !== due_res.flag_carry ||
            seen_res.flag_parity !== due_res.flag_parity ||
            seen_res.flag_aux !== due_res.flag_aux ||
            seen_res.flag_zero !== due_res.flag_zero ||
            seen_res.flag_sign !== due_res.flag_sign ||
            seen_res.flag_overflow !== due_res.flag_overflow) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $display("%0t: mismatch on result %0d", $realtime, results_checked);
            $display("  expected %s", fmt_res(due_res));
            $display("  actual   %s", fmt_res(seen_res));
          end
        end
      end
    end
  end

  // End the run when no word moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    alu_op_t nxt;
    // operation, size, operand_a, operand_b, carry_in; hand-worked result where simple:
    // result, wb, CF, PF, AF, ZF, SF, OF
    directed_ops = '{
      '{'{ACT_ADD, WIDTH_BYTE, 32'h0, 32'h0, 1'b0}, 1'b1,
        '{32'h0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0}},
      '{'{ACT_ADD, WIDTH_BYTE, 32'hff, 32'h01, 1'b0}, 1'b1,
        '{32'h0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}},
      '{'{ACT_ADD, WIDTH_BYTE, 32'h7f, 32'h01, 1'b0}, 1'b1,
        '{32'h80, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1}},
      '{'{ACT_ADC, WIDTH_WORD, 32'hffff, 32'h0, 1'b1}, 1'b1,
        '{32'h0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}},
      '{'{ACT_SUB, WIDTH_DWORD, 32'h0, 32'h1, 1'b0}, 1'b1,
        '{32'hffff_ffff, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0}},
      '{'{ACT_SBB, WIDTH_DWORD, 32'h8000_0000, 32'h0, 1'b1}, 1'b1,
        '{32'h7fff_ffff, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1}},
      '{'{ACT_CMP, WIDTH_BYTE, 32'h05, 32'h05, 1'b1}, 1'b1,
        '{32'h0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0}},
      '{'{ACT_AND, WIDTH_DWORD, 32'hffff_ffff, 32'hffff_ffff, 1'b1}, 1'b1,
        '{32'hffff_ffff, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}},
      '{'{ACT_OR, WIDTH_WORD, 32'hffff_0000, 32'habcd_0000, 1'b0}, 1'b1,
        '{32'h0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0}},
      '{'{ACT_XOR, WIDTH_BYTE, 32'h1234_56a5, 32'hfedc_baff, 1'b0}, 1'b1,
        '{32'h5a, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{'{ACT_SHL, WIDTH_BYTE, 32'h80, 32'hffff_ffff, 1'b1}, 1'b1,
        '{32'h0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1}},
      '{'{ACT_SHL, WIDTH_BYTE, 32'h40, 32'h0, 1'b0}, 1'b1,
        '{32'h80, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1}},
      '{'{ACT_SHL, WIDTH_DWORD, 32'hc000_0000, 32'h0, 1'b0}, 1'b1,
        '{32'h8000_0000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}},
      // spare size code acts as doubleword
      '{'{ACT_ADD, WIDTH_SPARE, 32'hffff_ffff, 32'h1, 1'b0}, 1'b1,
        '{32'h0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}},
      // unknown operations return all zeros
      '{'{ACT_UNKNOWN_LO, WIDTH_DWORD, 32'hffff_ffff, 32'hffff_ffff, 1'b1}, 1'b1, '0},
      '{'{ACT_UNKNOWN_HI, WIDTH_BYTE, 32'h1234_5678, 32'h9abc_def0, 1'b0}, 1'b1, '0},
      '{'{ACT_ADC, WIDTH_BYTE, 32'h3c, 32'h0e, 1'b0}, 1'b0, '0},
      '{'{ACT_ADC, WIDTH_DWORD, 32'h7fff_ffff, 32'h0, 1'b1}, 1'b0, '0},
      '{'{ACT_SBB, WIDTH_WORD, 32'h1234, 32'h1234, 1'b0}, 1'b0, '0},
      '{'{ACT_SBB, WIDTH_WORD, 32'h0, 32'hffff, 1'b1}, 1'b0, '0},
      '{'{ACT_CMP, WIDTH_DWORD, 32'h1, 32'h8000_0000, 1'b0}, 1'b0, '0},
      '{'{ACT_SUB, WIDTH_WORD, 32'h8000, 32'h1, 1'b1}, 1'b0, '0},
      '{'{ACT_SHL, WIDTH_WORD, 32'h4000, 32'ha5a5, 1'b0}, 1'b0, '0},
      '{'{ACT_ADD, WIDTH_WORD, 32'h5a5a_0f0f, 32'ha5a5_0101, 1'b0}, 1'b0, '0}
    };

    // Hold reset, then release it
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Three idle patterns: sender-heavy, receiver-heavy, none
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 48 : 0;
      recv_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 29 : 0;
      if (ph == 0) begin
        foreach (directed_ops[i]) op_queue.push_back(directed_ops[i]);
      end
      repeat (RAND_PER_PHASE) begin
        nxt.req   = random_req();
        nxt.fixed = 1'b0;
        nxt.want  = '0;
        op_queue.push_back(nxt);
      end
      while (op_queue.size() != 0 || s_axis_tvalid || results_due.size() != 0)
        @(negedge clk_i);
    end

    // Let any stray word come out
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (results_due.size() != 0) begin
      $display("%0d expected results never arrived", results_due.size());
      fail_count += results_due.size();
    end

    $display("Drove %0d operation words (%0d directed): all nine operations, three sizes,",
             ops_sent, DIR_ROWS);
    $display("spare size code and unknown codes; compared %0d results, %0d failures",
             results_checked, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/xalu_pkg.sv
rtl/xalu_core.sv
rtl/x86_alu_with_flags_unit.sv
sim/tb_x86_alu_with_flags_unit.sv
